// ===== rtl/tcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfp_pkg
// Shared constants and types of the telemetry command frame parser.
// ----------------------------------------------------------------------------
package tcfp_pkg;

  // Number of 16-bit payload words in a gain frame.
  localparam int unsigned MaxWords      = 24;
  localparam int unsigned SetpointWords = 10;
  localparam int unsigned SetpointEmit  = 4;
  localparam int unsigned PayloadStart  = 4;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned IndexW = 5;
  localparam int unsigned AddrW  = $clog2(MaxWords);
  localparam int unsigned PosW   = $clog2(2 * MaxWords + PayloadStart + 1);

  localparam logic [ByteW-1:0] Hdr0       = 8'hAA;
  localparam logic [ByteW-1:0] Hdr1       = 8'hAF;
  localparam logic [ByteW-1:0] FnGain     = 8'h10;
  localparam logic [ByteW-1:0] FnSetpoint = 8'h03;

  localparam logic [PosW-1:0] PosHdr0   = PosW'(0);
  localparam logic [PosW-1:0] PosHdr1   = PosW'(1);
  localparam logic [PosW-1:0] PosFunc   = PosW'(2);
  localparam logic [PosW-1:0] PosLength = PosW'(3);
  localparam logic [PosW-1:0] PosPay    = PosW'(PayloadStart);

  localparam logic [PosW-1:0] GainBytes     = PosW'(2 * MaxWords);
  localparam logic [PosW-1:0] SetpointBytes = PosW'(2 * SetpointWords);

  localparam logic KindGain     = 1'b0;
  localparam logic KindSetpoint = 1'b1;

  // Word store write port.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] data;
  } tcfp_wr_t;

  // Request for a run of results, raised by the checksum byte.
  typedef struct packed {
    logic start;
    logic err;
    logic kind;
  } tcfp_run_t;

endpackage

// ===== rtl/tcfp_word_store.sv =====
// ----------------------------------------------------------------------------
// tcfp_word_store
// Flip-flop store of the payload words of the current frame.
// ----------------------------------------------------------------------------
module tcfp_word_store (
  input  logic                                clk_i,
  input  tcfp_pkg::tcfp_wr_t                  wr_i,
  input  logic [tcfp_pkg::AddrW-1:0]          rd_addr_i,
  output logic [tcfp_pkg::WordW-1:0]          rd_data_o
);

  logic [tcfp_pkg::WordW-1:0] mem_q [tcfp_pkg::MaxWords];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule

// ===== rtl/tcfp_parser.sv =====
// ----------------------------------------------------------------------------
// tcfp_parser
// Per-byte frame parser: header check, function decode, word gathering and
// checksum compare.
// ----------------------------------------------------------------------------
module tcfp_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [tcfp_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                           frame_start_i,
  output tcfp_pkg::tcfp_wr_t             wr_o,
  output tcfp_pkg::tcfp_run_t            run_o
);

  localparam int unsigned PW = tcfp_pkg::PosW;
  localparam int unsigned AW = tcfp_pkg::AddrW;

  logic                       in_frame_q, in_frame_d, in_frame_v;
  logic [PW-1:0]              pos_q, pos_d, pos_v;
  logic                       kind_q, kind_d;
  logic [tcfp_pkg::ByteW-1:0] sum_q, sum_d, sum_v;
  logic [tcfp_pkg::ByteW-1:0] low_q, low_d, low_v;
  logic [PW-1:0]              off;
  logic [PW-1:0]              pay_bytes;

  assign pay_bytes = (kind_q == tcfp_pkg::KindSetpoint) ? tcfp_pkg::SetpointBytes
                                                         : tcfp_pkg::GainBytes;

  always_comb begin
    in_frame_v = in_frame_q;
    pos_v      = pos_q;
    sum_v      = sum_q;
    low_v      = low_q;
    kind_d     = kind_q;
    off        = pos_q - tcfp_pkg::PosPay;
    wr_o       = '0;
    run_o      = '0;

    if (accept_i) begin
      // A frame start restarts parsing, dropping any frame in progress.
      if (frame_start_i) begin
        in_frame_v = 1'b1;
        pos_v      = '0;
        sum_v      = '0;
        low_v      = '0;
      end
      off = pos_v - tcfp_pkg::PosPay;

      if (in_frame_v) begin
        case (pos_v)
          tcfp_pkg::PosHdr0: begin
            if (rx_byte_i != tcfp_pkg::Hdr0) in_frame_v = 1'b0;
          end
          tcfp_pkg::PosHdr1: begin
            if (rx_byte_i != tcfp_pkg::Hdr1) in_frame_v = 1'b0;
          end
          tcfp_pkg::PosFunc: begin
            if (rx_byte_i == tcfp_pkg::FnGain) begin
              kind_d = tcfp_pkg::KindGain;
            end else if (rx_byte_i == tcfp_pkg::FnSetpoint) begin
              kind_d = tcfp_pkg::KindSetpoint;
            end else begin
              in_frame_v = 1'b0;
            end
          end
          tcfp_pkg::PosLength: begin
            // The length byte carries nothing the parser needs.
          end
          default: begin
            if (off < pay_bytes) begin
              sum_v = sum_v + rx_byte_i;
              if (!off[0]) begin
                low_v = rx_byte_i;
              end else begin
                wr_o.en   = 1'b1;
                wr_o.addr = off[AW:1];
                wr_o.data = {rx_byte_i, low_v};
              end
            end else begin
              run_o.start = 1'b1;
              run_o.err   = (rx_byte_i != sum_v);
              run_o.kind  = kind_q;
              in_frame_v  = 1'b0;
            end
          end
        endcase

        if (in_frame_v) pos_v = pos_v + PW'(1);
      end
    end

    in_frame_d = in_frame_v;
    pos_d      = pos_v;
    sum_d      = sum_v;
    low_d      = low_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      kind_q     <= 1'b0;
      sum_q      <= '0;
      low_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      sum_q      <= sum_d;
      low_q      <= low_d;
    end
  end

endmodule

// ===== rtl/tcfp_emitter.sv =====
// ----------------------------------------------------------------------------
// tcfp_emitter
// Walks the word store for a committed frame and drives the result register.
// ----------------------------------------------------------------------------
module tcfp_emitter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcfp_pkg::tcfp_run_t            run_i,
  output logic [tcfp_pkg::AddrW-1:0]     rd_addr_o,
  input  logic [tcfp_pkg::WordW-1:0]     rd_data_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           status_o,
  output logic                           frame_kind_o,
  output logic [tcfp_pkg::IndexW-1:0]    word_index_o,
  output logic [tcfp_pkg::WordW-1:0]     word_value_o,
  output logic                           last_o
);

  localparam int unsigned AW = tcfp_pkg::AddrW;
  localparam int unsigned IW = tcfp_pkg::IndexW;

  logic          active_q, active_d;
  logic          err_q, err_d;
  logic          kind_q, kind_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] last_idx_q, last_idx_d;
  logic          load;
  logic          is_last;

  logic                       out_valid_q, out_valid_d;
  logic                       status_q, status_d;
  logic                       okind_q, okind_d;
  logic [IW-1:0]              oidx_q, oidx_d;
  logic [tcfp_pkg::WordW-1:0] oval_q, oval_d;
  logic                       olast_q, olast_d;

  // A result enters the output register whenever that register is free or draining.
  assign load    = active_q && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == last_idx_q);

  always_comb begin
    active_d    = active_q;
    err_d       = err_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    okind_d     = okind_q;
    oidx_d      = oidx_q;
    oval_d      = oval_q;
    olast_d     = olast_q;

    if (out_ready_i) out_valid_d = 1'b0;

    if (load) begin
      out_valid_d = 1'b1;
      status_d    = err_q;
      okind_d     = kind_q;
      oidx_d      = IW'(idx_q);
      oval_d      = err_q ? '0 : rd_data_i;
      olast_d     = is_last;
      if (is_last) active_d = 1'b0;
      else         idx_d    = idx_q + AW'(1);
    end

    if (run_i.start) begin
      active_d = 1'b1;
      err_d    = run_i.err;
      kind_d   = run_i.kind;
      idx_d    = '0;
      if (run_i.err) begin
        last_idx_d = '0;
      end else if (run_i.kind == tcfp_pkg::KindSetpoint) begin
        last_idx_d = AW'(tcfp_pkg::SetpointEmit - 1);
      end else begin
        last_idx_d = AW'(tcfp_pkg::MaxWords - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
    status_q   <= status_d;
    okind_q    <= okind_d;
    oidx_q     <= oidx_d;
    oval_q     <= oval_d;
    olast_q    <= olast_d;
  end

  assign rd_addr_o    = idx_q;
  assign busy_o       = active_q;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign frame_kind_o = okind_q;
  assign word_index_o = oidx_q;
  assign word_value_o = oval_q;
  assign last_o       = olast_q;

endmodule

// ===== rtl/telemetry_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// telemetry_command_frame_parser
// Parses gain and setpoint command frames with an additive checksum and
// emits the committed payload words, or one error result on a mismatch.
// ----------------------------------------------------------------------------
// One byte item is taken per cycle unless the input stalls; the parse state
// updates in that cycle. The checksum byte sets the emitter's registered active
// flag, then the first result enters the output register, then one result per
// cycle while the output is ready: 24 for a gain frame, 4 for a setpoint frame, 1
// on error. The input stalls until the last result enters the output register.
// Reset (rst_ni low, asynchronous) clears the parse and output control state.
module telemetry_command_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [4:0] word_index, [20:5] word_value, zero fill
  output logic [1:0]  m_axis_tuser_o,   // [0] status, [1] frame_kind
  output logic        m_axis_tlast_o
);

  tcfp_pkg::tcfp_wr_t           wr;
  tcfp_pkg::tcfp_run_t          run_req;
  logic                         accept;
  logic                         busy;
  logic [tcfp_pkg::AddrW-1:0]   rd_addr;
  logic [tcfp_pkg::WordW-1:0]   rd_data;
  logic [tcfp_pkg::IndexW-1:0]  word_index;
  logic [tcfp_pkg::WordW-1:0]   word_value;
  logic                         status;
  logic                         frame_kind;

  // The store must not change while a committed run is read out.
  assign s_axis_tready_o = !busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  tcfp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .wr_o          (wr),
    .run_o         (run_req)
  );

  tcfp_word_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tcfp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_i        (run_req),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .busy_o       (busy),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .frame_kind_o (frame_kind),
    .word_index_o (word_index),
    .word_value_o (word_value),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, word_value, word_index};
  assign m_axis_tuser_o = {frame_kind, status};

`ifndef SYNTH
  a_error_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status) |-> (m_axis_tlast_o && word_index == '0 && word_value == '0))
    else $error("error result carries a word or is not last");

  a_setpoint_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !status && frame_kind == tcfp_pkg::KindSetpoint)
      |-> (word_index < tcfp_pkg::IndexW'(tcfp_pkg::SetpointEmit)))
    else $error("setpoint result beyond committed words");

  a_run_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_req.start |-> !busy)
    else $error("new run requested while a run is being emitted");

  a_no_write_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !wr.en)
    else $error("word store written during a run");
`endif

endmodule
